[hdl/cruise_target_setpoint_repeat_macros.svh]
// Assertion macros for the cruise target setpoint block.
// Included by the top level; relies on clk and rst being in scope.
`ifndef CRUISE_TARGET_SETPOINT_REPEAT_MACROS_SVH
`define CRUISE_TARGET_SETPOINT_REPEAT_MACROS_SVH

// Clocked assertion that is held off while reset is high.
`define CTSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ctsr_pkg.sv]
// Shared types and constants for the cruise target setpoint block.
// Used by ctsr_alu and cruise_target_setpoint_repeat; depends on nothing.
package ctsr_pkg;

  // Width of the shared adder: a 32-bit count plus a carry/sign bit.
  localparam int AluW = 33;

  // Register indexes of the configuration port.
  localparam logic [0:0] CFG_STEP = 1'b0;
  localparam logic [0:0] CFG_MAX  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [14:0] STEP_RESET = 15'd100;
  localparam logic [14:0] MAX_RESET  = 15'd3000;

  // Input item kinds.
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_VELOCITY = 3'd1,
    OP_NEUTRAL  = 3'd2,
    OP_PLUS     = 3'd3,
    OP_MINUS    = 3'd4,
    OP_SET      = 3'd5,
    OP_OTHER    = 3'd6
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CMP,
    S_CNT,
    S_DONE
  } state_t;

  // Operation handed to the shared adder.
  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

  // Repeat reload in ticks, 1000 divided by the bit length of the count.
  localparam logic [9:0] ReloadTicks [33] = '{
    10'd1000, 10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd166, 10'd142,
    10'd125,  10'd111,  10'd100, 10'd90,  10'd83,  10'd76,  10'd71,  10'd66,
    10'd62,   10'd58,   10'd55,  10'd52,  10'd50,  10'd47,  10'd45,  10'd43,
    10'd41,   10'd40,   10'd38,  10'd37,  10'd35,  10'd34,  10'd33,  10'd32,
    10'd31
  };

endpackage

[hdl/ctsr_alu.sv]
// Shared add/subtract unit of the cruise target setpoint sequencer.
// Depends on ctsr_pkg for the operation struct and width.
module ctsr_alu (
  input  ctsr_pkg::alu_req_t              req,
  output logic [ctsr_pkg::AluW-1:0]       sum
);

  // One adder serves averaging, target stepping, clamping and counting.
  always_comb begin
    if (req.sub) begin
      sum = req.a - req.b;
    end else begin
      sum = req.a + req.b;
    end
  end

endmodule

[hdl/cruise_target_setpoint_repeat.sv]
// Cruise target setpoint with press-and-hold repeat. One input transaction yields exactly
// one result transaction. Ticks that only count down, velocity, neutral, plus, minus and
// other events pass through the execute and done states, set adds the compare state, and
// a repeat firing adds compare and count; a small sequencer runs every sum, compare and
// count increment through one shared 33-bit adder. A finished result waits in the output
// register, so the next input transaction is taken while it is pending.
`include "cruise_target_setpoint_repeat_macros.svh"

module cruise_target_setpoint_repeat (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic signed [15:0] left_velocity,
  input  logic signed [15:0] right_velocity,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        target_sent,
  output logic [14:0] target_value,
  output logic        speed_update,
  output logic [14:0] speed_value,
  output logic        handled,
  output logic        rejected,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int W = ctsr_pkg::AluW;

  ctsr_pkg::state_t state, state_next;

  // Latched input transaction.
  ctsr_pkg::op_t op_reg, op_reg_next;
  logic [15:0] left_reg, left_reg_next;
  logic [15:0] right_reg, right_reg_next;
  logic [16:0] req, req_next;

  // Block state.
  logic [14:0] target_speed, target_speed_next;
  logic [14:0] current_speed, current_speed_next;
  logic [31:0] repeat_count, repeat_count_next;
  logic [5:0]  count_len, count_len_next;
  logic [9:0]  ticks_left, ticks_left_next;
  logic        repeat_armed, repeat_armed_next;
  logic        step_down, step_down_next;
  logic [14:0] step_cms, step_cms_next;
  logic [14:0] max_target_cms, max_target_cms_next;

  // Per-transaction flags.
  logic fire, fire_next;
  logic sent_flag, sent_flag_next;
  logic upd_flag, upd_flag_next;
  logic hdl_flag, hdl_flag_next;
  logic rej_flag, rej_flag_next;

  // Output register.
  logic        out_valid_next;
  logic        target_sent_next;
  logic [14:0] target_value_next;
  logic        speed_update_next;
  logic [14:0] speed_value_next;
  logic        handled_next;
  logic        rejected_next;

  ctsr_pkg::alu_req_t alu_req;
  logic [W-1:0]       alu_sum;

  ctsr_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  assign in_ready  = (state == ctsr_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer: next state, shared adder operands and all state updates.
  always_comb begin
    state_next          = state;
    op_reg_next         = op_reg;
    left_reg_next       = left_reg;
    right_reg_next      = right_reg;
    req_next            = req;
    target_speed_next   = target_speed;
    current_speed_next  = current_speed;
    repeat_count_next   = repeat_count;
    count_len_next      = count_len;
    ticks_left_next     = ticks_left;
    repeat_armed_next   = repeat_armed;
    step_down_next      = step_down;
    step_cms_next       = step_cms;
    max_target_cms_next = max_target_cms;
    fire_next           = fire;
    sent_flag_next      = sent_flag;
    upd_flag_next       = upd_flag;
    hdl_flag_next       = hdl_flag;
    rej_flag_next       = rej_flag;
    out_valid_next      = out_valid & ~out_ready;
    target_sent_next    = target_sent;
    target_value_next   = target_value;
    speed_update_next   = speed_update;
    speed_value_next    = speed_value;
    handled_next        = handled;
    rejected_next       = rejected;
    alu_req             = '{a: '0, b: '0, sub: 1'b0};

    // The user must make configuration writes only while the block is idle; the block itself does not enforce this.
    if (cfg_valid) begin
      unique case (cfg_index)
        ctsr_pkg::CFG_STEP: step_cms_next       = cfg_data;
        ctsr_pkg::CFG_MAX:  max_target_cms_next = cfg_data;
        default:            step_cms_next       = step_cms;
      endcase
    end

    unique case (state)
      ctsr_pkg::S_IDLE: begin
        if (in_valid) begin
          op_reg_next    = ctsr_pkg::op_t'(op);
          left_reg_next  = left_velocity;
          right_reg_next = right_velocity;
          fire_next      = 1'b0;
          sent_flag_next = 1'b0;
          upd_flag_next  = 1'b0;
          hdl_flag_next  = 1'b0;
          rej_flag_next  = 1'b0;
          state_next     = ctsr_pkg::S_EXEC;
        end
      end

      ctsr_pkg::S_EXEC: begin
        state_next = ctsr_pkg::S_DONE;
        unique case (op_reg)
          ctsr_pkg::OP_TICK: begin
            if (repeat_armed) begin
              if (ticks_left > 10'd1) begin
                ticks_left_next = ticks_left - 10'd1;
              end else begin
                // Timer fires: form the stepped target request.
                alu_req    = '{a: W'(target_speed), b: W'(step_cms), sub: step_down};
                req_next   = alu_sum[16:0];
                fire_next  = 1'b1;
                state_next = ctsr_pkg::S_CMP;
              end
            end
          end
          ctsr_pkg::OP_VELOCITY: begin
            // Average of both wheels; a negative sum floors to zero.
            alu_req = '{a: {{(W-16){left_reg[15]}}, left_reg},
                        b: {{(W-16){right_reg[15]}}, right_reg},
                        sub: 1'b0};
            current_speed_next = alu_sum[W-1] ? 15'd0 : alu_sum[15:1];
            upd_flag_next      = 1'b1;
          end
          ctsr_pkg::OP_NEUTRAL: begin
            repeat_armed_next = 1'b0;
            ticks_left_next   = 10'd0;
            hdl_flag_next     = 1'b1;
          end
          ctsr_pkg::OP_PLUS, ctsr_pkg::OP_MINUS: begin
            repeat_count_next = 32'd0;
            count_len_next    = 6'd0;
            step_down_next    = (op_reg == ctsr_pkg::OP_MINUS);
            repeat_armed_next = 1'b1;
            ticks_left_next   = 10'd1;
            hdl_flag_next     = 1'b1;
          end
          ctsr_pkg::OP_SET: begin
            req_next      = {2'b00, current_speed};
            hdl_flag_next = 1'b1;
            state_next    = ctsr_pkg::S_CMP;
          end
          default: begin
            state_next = ctsr_pkg::S_DONE;
          end
        endcase
      end

      ctsr_pkg::S_CMP: begin
        // Refuse a negative request, otherwise clamp to the maximum.
        if (req[16]) begin
          rej_flag_next = 1'b1;
        end else begin
          alu_req = '{a: W'(max_target_cms), b: {{(W-17){1'b0}}, req}, sub: 1'b1};
          target_speed_next = alu_sum[W-1] ? max_target_cms : req[14:0];
          sent_flag_next    = 1'b1;
        end
        state_next = fire ? ctsr_pkg::S_CNT : ctsr_pkg::S_DONE;
      end

      ctsr_pkg::S_CNT: begin
        // Saturating count increment; the bit length grows at each power of two.
        alu_req = '{a: {1'b0, repeat_count}, b: W'(1), sub: 1'b0};
        if (!alu_sum[W-1]) begin
          repeat_count_next = alu_sum[31:0];
          if ((repeat_count & alu_sum[31:0]) == 32'd0) begin
            count_len_next = count_len + 6'd1;
          end
        end
        ticks_left_next = ctsr_pkg::ReloadTicks[count_len_next];
        state_next      = ctsr_pkg::S_DONE;
      end

      ctsr_pkg::S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          target_sent_next  = sent_flag;
          target_value_next = target_speed;
          speed_update_next = upd_flag;
          speed_value_next  = current_speed;
          handled_next      = hdl_flag;
          rejected_next     = rej_flag;
          state_next        = ctsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ctsr_pkg::S_IDLE;
      end
    endcase
  end

  // Control and block state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ctsr_pkg::S_IDLE;
      target_speed   <= '0;
      current_speed  <= '0;
      repeat_count   <= '0;
      count_len      <= '0;
      ticks_left     <= '0;
      repeat_armed   <= 1'b0;
      step_down      <= 1'b0;
      step_cms       <= ctsr_pkg::STEP_RESET;
      max_target_cms <= ctsr_pkg::MAX_RESET;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      target_speed   <= target_speed_next;
      current_speed  <= current_speed_next;
      repeat_count   <= repeat_count_next;
      count_len      <= count_len_next;
      ticks_left     <= ticks_left_next;
      repeat_armed   <= repeat_armed_next;
      step_down      <= step_down_next;
      step_cms       <= step_cms_next;
      max_target_cms <= max_target_cms_next;
      out_valid      <= out_valid_next;
    end
  end

  // Payload registers for the transaction in flight and the pending result.
  always_ff @(posedge clk) begin
    op_reg       <= op_reg_next;
    left_reg     <= left_reg_next;
    right_reg    <= right_reg_next;
    req          <= req_next;
    fire         <= fire_next;
    sent_flag    <= sent_flag_next;
    upd_flag     <= upd_flag_next;
    hdl_flag     <= hdl_flag_next;
    rej_flag     <= rej_flag_next;
    target_sent  <= target_sent_next;
    target_value <= target_value_next;
    speed_update <= speed_update_next;
    speed_value  <= speed_value_next;
    handled      <= handled_next;
    rejected     <= rejected_next;
  end

  // While the repeat timer is armed it always has a tick to count.
  `CTSR_ASSERT(a_armed_ticks, repeat_armed |-> (ticks_left != 10'd0), "armed timer with zero ticks")
  // The tracked bit length is zero exactly when the count is zero.
  `CTSR_ASSERT(a_len_count, (repeat_count == 32'd0) == (count_len == 6'd0), "bit length out of step")
  // A result never reports a target both sent and rejected.
  `CTSR_ASSERT(a_sent_rej, out_valid |-> !(target_sent && rejected), "target both sent and rejected")

endmodule
